@@ rtl/core/bpr_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the BMP pixel row decoder.
// No dependencies; every other file of the block refers to it by scoped names.
package bpr_pkg;

  // Input beat kinds (tuser)
  localparam logic [1:0] KIND_PAL_WR = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_SOF    = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // Pixel modes
  localparam logic [2:0] MODE_1BPP  = 3'd0;
  localparam logic [2:0] MODE_4BPP  = 3'd1;
  localparam logic [2:0] MODE_8BPP  = 3'd2;
  localparam logic [2:0] MODE_555A  = 3'd3;
  localparam logic [2:0] MODE_565   = 3'd4;
  localparam logic [2:0] MODE_4444  = 3'd5;
  localparam logic [2:0] MODE_24BPP = 3'd6;
  localparam logic [2:0] MODE_32BPP = 3'd7;

  // Image size limits (register values above saturate)
  localparam logic [12:0] MAX_WIDTH  = 13'd4096;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;

  // Configuration register file
  typedef struct packed {
    logic [2:0]  pixel_mode;
    logic [12:0] image_width;
    logic [12:0] image_height;
  } cfg_t;

  // One unit of work for the pixel expander
  typedef struct packed {
    logic        is_wr;     // palette write, no pixel out
    logic        indexed;   // palette pixels unpacked from data
    logic [7:0]  pal_addr;
    logic [23:0] pal_rgb;   // R,G,B from high to low
    logic [7:0]  data;      // raw byte for indexed modes
    logic [2:0]  mode;
    logic [3:0]  count;     // pixels in this job, 1..8
    logic [11:0] col;       // column of first pixel
    logic [11:0] row;
    logic [31:0] rgba;      // R,G,B,A of a direct pixel
  } job_t;

endpackage

@@ rtl/core/bpr_front.sv @@
`timescale 1ns / 1ps
// Frame position tracking and per-beat decode into expander jobs.
// Depends on bpr_pkg.
module bpr_front (
  input  logic          clk,
  input  logic          rst,
  input  bpr_pkg::cfg_t cfg,
  input  logic          accept,
  input  logic [1:0]    kind,
  input  logic [7:0]    palette_index,
  input  logic [7:0]    palette_red,
  input  logic [7:0]    palette_green,
  input  logic [7:0]    palette_blue,
  input  logic [7:0]    data_byte,
  output bpr_pkg::job_t job,
  output logic          job_load
);

  // Frame state
  logic [13:0] row_byte_count;
  logic [1:0]  byte_mod3;
  logic [12:0] pixel_column;
  logic [12:0] rows_done;
  logic [23:0] partial_pixel;

  logic [13:0] row_byte_count_next;
  logic [1:0]  byte_mod3_next;
  logic [12:0] pixel_column_next;
  logic [12:0] rows_done_next;
  logic [23:0] partial_pixel_next;

  logic [12:0] w, h;
  logic        active, col_ok, is_indexed, last_byte;
  logic [17:0] row_bits, row_bits_rnd;
  logic [14:0] stride, rbc_inc;
  logic [12:0] remain;
  logic [3:0]  per, cnt;
  logic [1:0]  sub;
  logic [23:0] base;
  logic [31:0] shifted, v;
  logic [7:0]  r, g, b, a;
  logic [12:0] row_full;

  // Saturate the size and derive the padded row length
  always_comb begin
    w = (cfg.image_width > bpr_pkg::MAX_WIDTH) ? bpr_pkg::MAX_WIDTH : cfg.image_width;
    h = (cfg.image_height > bpr_pkg::MAX_HEIGHT) ? bpr_pkg::MAX_HEIGHT : cfg.image_height;
    case (cfg.pixel_mode)
      bpr_pkg::MODE_1BPP:  row_bits = {5'd0, w};
      bpr_pkg::MODE_4BPP:  row_bits = {3'd0, w, 2'd0};
      bpr_pkg::MODE_8BPP:  row_bits = {2'd0, w, 3'd0};
      bpr_pkg::MODE_24BPP: row_bits = {1'b0, w, 4'd0} + {2'd0, w, 3'd0};
      bpr_pkg::MODE_32BPP: row_bits = {w, 5'd0};
      default:             row_bits = {1'b0, w, 4'd0};
    endcase
    row_bits_rnd = row_bits + 18'd31;
    stride       = {row_bits_rnd[17:5], 2'b00};
    active       = (w != 13'd0) && (h != 13'd0) && (rows_done < h);
    col_ok       = pixel_column < w;
    is_indexed   = cfg.pixel_mode inside {bpr_pkg::MODE_1BPP, bpr_pkg::MODE_4BPP,
                                          bpr_pkg::MODE_8BPP};
    row_full     = h - 13'd1 - rows_done;
  end

  // Pixels of one indexed byte, clipped at the row end
  always_comb begin
    case (cfg.pixel_mode)
      bpr_pkg::MODE_1BPP: per = 4'd8;
      bpr_pkg::MODE_4BPP: per = 4'd2;
      default:            per = 4'd1;
    endcase
    remain = w - pixel_column;
    cnt    = (remain < {9'd0, per}) ? remain[3:0] : per;
  end

  // Byte position within a multi-byte pixel and pixel assembly
  always_comb begin
    case (cfg.pixel_mode)
      bpr_pkg::MODE_24BPP: begin
        sub       = byte_mod3;
        last_byte = (byte_mod3 == 2'd2);
      end
      bpr_pkg::MODE_32BPP: begin
        sub       = row_byte_count[1:0];
        last_byte = (row_byte_count[1:0] == 2'd3);
      end
      default: begin
        sub       = {1'b0, row_byte_count[0]};
        last_byte = row_byte_count[0];
      end
    endcase
    base    = (sub == 2'd0) ? 24'd0 : partial_pixel;
    shifted = {24'd0, data_byte} << {sub, 3'b000};
    v       = {8'd0, base} | shifted;
    case (cfg.pixel_mode)
      bpr_pkg::MODE_555A: begin
        b = {v[4:0], 3'b000};
        g = {v[9:5], 3'b000};
        r = {v[14:10], 3'b000};
        a = v[15] ? 8'd0 : 8'd255;
      end
      bpr_pkg::MODE_565: begin
        b = {v[4:0], 3'b000};
        g = {v[10:5], 2'b00};
        r = {v[15:11], 3'b000};
        a = 8'd255;
      end
      bpr_pkg::MODE_4444: begin
        b = {v[3:0], 4'h0};
        g = {v[7:4], 4'h0};
        r = {v[11:8], 4'h0};
        a = {v[15:12], 4'h0};
      end
      bpr_pkg::MODE_24BPP: begin
        b = v[7:0];
        g = v[15:8];
        r = v[23:16];
        a = 8'd255;
      end
      default: begin
        b = base[7:0];
        g = base[15:8];
        r = base[23:16];
        a = data_byte;
      end
    endcase
  end

  // Next frame state and job build
  always_comb begin
    row_byte_count_next = row_byte_count;
    byte_mod3_next      = byte_mod3;
    pixel_column_next   = pixel_column;
    rows_done_next      = rows_done;
    partial_pixel_next  = partial_pixel;
    rbc_inc             = {1'b0, row_byte_count} + 15'd1;
    job_load            = 1'b0;

    job.is_wr    = (kind == bpr_pkg::KIND_PAL_WR);
    job.indexed  = is_indexed;
    job.pal_addr = palette_index;
    job.pal_rgb  = {palette_red, palette_green, palette_blue};
    job.data     = data_byte;
    job.mode     = cfg.pixel_mode;
    job.count    = is_indexed ? cnt : 4'd1;
    job.col      = pixel_column[11:0];
    job.row      = row_full[11:0];
    job.rgba     = {r, g, b, a};

    if (accept) begin
      case (kind)
        bpr_pkg::KIND_PAL_WR: job_load = 1'b1;
        bpr_pkg::KIND_SOF: begin
          row_byte_count_next = '0;
          byte_mod3_next      = '0;
          pixel_column_next   = '0;
          rows_done_next      = '0;
          partial_pixel_next  = '0;
        end
        bpr_pkg::KIND_DATA: begin
          if (active) begin
            if (col_ok) begin
              if (is_indexed) begin
                job_load          = 1'b1;
                pixel_column_next = pixel_column + {9'd0, cnt};
              end else if (last_byte) begin
                job_load           = 1'b1;
                pixel_column_next  = pixel_column + 13'd1;
                partial_pixel_next = '0;
              end else begin
                partial_pixel_next = base | shifted[23:0];
              end
            end
            // Advance within the padded row; close the row at its end
            if (rbc_inc >= stride) begin
              row_byte_count_next = '0;
              byte_mod3_next      = '0;
              pixel_column_next   = '0;
              partial_pixel_next  = '0;
              rows_done_next      = rows_done + 13'd1;
            end else begin
              row_byte_count_next = rbc_inc[13:0];
              byte_mod3_next      = (byte_mod3 == 2'd2) ? 2'd0 : byte_mod3 + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_byte_count <= '0;
      byte_mod3      <= '0;
      pixel_column   <= '0;
      rows_done      <= '0;
      partial_pixel  <= '0;
    end else begin
      row_byte_count <= row_byte_count_next;
      byte_mod3      <= byte_mod3_next;
      pixel_column   <= pixel_column_next;
      rows_done      <= rows_done_next;
      partial_pixel  <= partial_pixel_next;
    end
  end

endmodule

@@ rtl/core/bpr_expand.sv @@
`timescale 1ns / 1ps
// Job register, palette memory and pixel output stage: one pixel per beat.
// Depends on bpr_pkg.
module bpr_expand #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  bpr_pkg::job_t job_in,
  input  logic          job_load,
  output logic          slot_free,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    red,
  output logic [7:0]    green,
  output logic [7:0]    blue,
  output logic [7:0]    alpha,
  output logic [11:0]   column,
  output logic [11:0]   row,
  output logic          last
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [23:0] palette [PALETTE_DEPTH];
  logic [23:0] pal_q;

  bpr_pkg::job_t job;
  logic          job_valid;
  logic [2:0]    k;

  logic          out_use_pal;
  logic [31:0]   out_rgba;

  logic          s2_ready, head_wr, issue, last_issue, job_done, idx_ok, wr_ok;
  logic [7:0]    idx;

  // Pick the palette index of pixel k, most significant bits first
  always_comb begin
    case (job.mode)
      bpr_pkg::MODE_1BPP: idx = {7'd0, job.data[3'd7 - k]};
      bpr_pkg::MODE_4BPP: idx = k[0] ? {4'd0, job.data[3:0]} : {4'd0, job.data[7:4]};
      default:            idx = job.data;
    endcase
    idx_ok     = {1'b0, idx} < 9'(PALETTE_DEPTH);
    wr_ok      = {1'b0, job.pal_addr} < 9'(PALETTE_DEPTH);
    s2_ready   = !out_valid || out_ready;
    head_wr    = job_valid && job.is_wr;
    issue      = job_valid && !job.is_wr && s2_ready;
    last_issue = issue && (({1'b0, k} + 4'd1) == job.count);
    job_done   = head_wr || last_issue;
    slot_free  = !job_valid || job_done;
  end

  // Hold the current job and step through its pixels
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      k         <= '0;
    end else if (job_load) begin
      job_valid <= 1'b1;
      k         <= '0;
    end else if (job_done) begin
      job_valid <= 1'b0;
    end else if (issue) begin
      k <= k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job <= job_in;
    end
  end

  // Palette: writes in job order, registered read held while stalled
  always_ff @(posedge clk) begin
    if (head_wr && wr_ok) begin
      palette[job.pal_addr[AW-1:0]] <= job.pal_rgb;
    end
    if (issue && job.indexed) begin
      pal_q <= palette[idx[AW-1:0]];
    end
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_use_pal <= job.indexed && idx_ok;
      out_rgba    <= job.indexed ? {24'd0, 8'd255} : job.rgba;
      column      <= job.col + {9'd0, k};
      row         <= job.row;
      last        <= ({1'b0, k} + 4'd1) == job.count;
    end
  end

  assign red   = out_use_pal ? pal_q[23:16] : out_rgba[31:24];
  assign green = out_use_pal ? pal_q[15:8]  : out_rgba[23:16];
  assign blue  = out_use_pal ? pal_q[7:0]   : out_rgba[15:8];
  assign alpha = out_rgba[7:0];

endmodule

@@ rtl/core/bmp_pixel_row_decoder_top.sv @@
`timescale 1ns / 1ps
// BMP pixel row decoder: bottom-up BMP pixel bytes in, RGBA pixels with position out.
// The job register loads on the accepting edge of a byte; its first pixel then passes to the output
// register, which takes it once the output stage is free.
// Throughput: one output pixel per cycle while m_tready is high; a byte giving n pixels (up to 8 at
// 1 bpp) holds the input until its last pixel is issued, since the single palette read port serves one pixel at a time.
// Reset clears frame position, job and output valid; config returns to 32 bpp, 1x1.
// Palette contents are undefined after reset until written.
module bmp_pixel_row_decoder_top #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // palette_index, palette_red, palette_green,
                                 // palette_blue, data_byte
  input  logic [1:0]  s_tuser,   // kind
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // red, green, blue, alpha, column, row
  output logic        m_tlast    // last pixel of the input beat
);

  bpr_pkg::cfg_t cfg;
  bpr_pkg::job_t job;
  logic          job_load;
  logic          slot_free;
  logic          accept;
  logic [7:0]    red, green, blue, alpha;
  logic [11:0]   column, row;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_mode   <= bpr_pkg::MODE_32BPP;
      cfg.image_width  <= 13'd1;
      cfg.image_height <= 13'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        bpr_pkg::CFG_MODE:   cfg.pixel_mode   <= cfg_data[2:0];
        bpr_pkg::CFG_WIDTH:  cfg.image_width  <= cfg_data;
        bpr_pkg::CFG_HEIGHT: cfg.image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = slot_free;
  assign accept   = s_tvalid && s_tready;

  bpr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .accept        (accept),
    .kind          (s_tuser),
    .palette_index (s_tdata[7:0]),
    .palette_red   (s_tdata[15:8]),
    .palette_green (s_tdata[23:16]),
    .palette_blue  (s_tdata[31:24]),
    .data_byte     (s_tdata[39:32]),
    .job           (job),
    .job_load      (job_load)
  );

  bpr_expand #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_expand (
    .clk       (clk),
    .rst       (rst),
    .job_in    (job),
    .job_load  (job_load),
    .slot_free (slot_free),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .column    (column),
    .row       (row),
    .last      (m_tlast)
  );

  assign m_tdata = {row, column, alpha, blue, green, red};

  // A job is only loaded into a free slot
  a_load_free: assert property (@(posedge clk) disable iff (rst) job_load |-> slot_free)
    else $error("job loaded while expander busy");

  // Reset leaves no pixel pending on the output
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // Reset leaves the input open
  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

endmodule
